// File: src/pme_pkg.sv
// Package for the permutation move engine: sizes, function codes,
// request/response word layouts and controller state encoding.
// No dependencies.
`timescale 1ns / 1ps

package pme_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 16;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FUNC_W     = 3;
  localparam int POS_W      = 6;
  localparam int VALUE_W    = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE      = 3'd0,
    FN_READ       = 3'd1,
    FN_SWAP       = 3'd2,
    FN_INSERT     = 3'd3,
    FN_REV_INSERT = 3'd4,
    FN_INVERT     = 3'd5
  } func_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   pos_a;
    logic [POS_W-1:0]   pos_b;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [POS_W-1:0]   read_pos;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_PAIR_RD,
    ST_PAIR_WA,
    ST_PAIR_WB,
    ST_SHIFT,
    ST_TAIL
  } state_t;

endpackage

// File: src/pme_ram.sv
// Element store of the permutation move engine: one write port and two
// registered read ports. Generic; no package dependency.
`timescale 1ns / 1ps

module pme_ram #(
  parameter int DEPTH_P = 64,
  parameter int ADDR_W  = 6,
  parameter int DATA_W  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/permutation_move_engine_core.sv
// Top level of the permutation move engine: controller around the element store.
// Depends on pme_pkg and pme_ram.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req): one command per request:
//   write, read, swap, insertion, reverse insertion or inversion. Response
//   channel (rsp_valid / rsp_stall / rsp): one response for each read, none
//   for anything else. Requests are taken one at a time; req_stall is high
//   while a command is still at work.
//   A write finishes in its accepting cycle. A null move (equal or
//   out-of-range positions, unused codes) changes nothing and leaves
//   req_stall low. Moves are paced by the store's single write port:
//   every moved element takes one write, and each inversion pair after
//   the first also takes a read state (ST_PAIR_RD).
//   Reads: the store read is registered, then ST_RESP loads the response
//   into the output register once that register is free. A waiting
//   response does not block moves or writes; a following read waits until
//   the register frees up.
//   Reset clears the controller and the response valid; store contents are
//   undefined until written. While rsp_stall is high the response holds.

module permutation_move_engine_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pme_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pme_pkg::rsp_t rsp
);

  pme_pkg::state_t state, state_next;

  // Pointers: for pair moves a_ptr/b_ptr are lo/hi, for shifts a_ptr is the
  // destination being filled and b_ptr the end where the held element lands.
  logic [pme_pkg::ADDR_W-1:0]     a_ptr, b_ptr;
  logic                           dir_up;
  logic                           is_inv;
  logic                           first;
  logic [pme_pkg::ELEM_WIDTH-1:0] held;
  logic [pme_pkg::POS_W-1:0]      rd_pos;
  logic                           rd_oob;

  // Store ports
  logic                           ram_we;
  logic [pme_pkg::ADDR_W-1:0]     ram_waddr;
  logic [pme_pkg::ELEM_WIDTH-1:0] ram_wdata;
  logic [pme_pkg::ADDR_W-1:0]     raddr_a, raddr_b;
  logic [pme_pkg::ELEM_WIDTH-1:0] rdata_a, rdata_b;

  logic                           rsp_load;

  // Request decode
  logic                       acc;
  logic                       in_a, in_b;
  logic                       req_move;
  logic [pme_pkg::ADDR_W-1:0] pa, pb, req_lo, req_hi;
  logic [pme_pkg::ADDR_W-1:0] step_ptr;
  logic                       last_shift;
  logic                       more_pairs;

  assign req_stall = (state != pme_pkg::ST_IDLE);
  assign acc       = req_valid && !req_stall;

  assign in_a   = int'(req.pos_a) < pme_pkg::DEPTH;
  assign in_b   = int'(req.pos_b) < pme_pkg::DEPTH;
  assign pa     = pme_pkg::ADDR_W'(req.pos_a);
  assign pb     = pme_pkg::ADDR_W'(req.pos_b);
  assign req_lo = (pa < pb) ? pa : pb;
  assign req_hi = (pa < pb) ? pb : pa;

  assign req_move = (req.func >= pme_pkg::FN_SWAP) && (req.func <= pme_pkg::FN_INVERT)
                    && in_a && in_b && (req.pos_a != req.pos_b);

  assign step_ptr   = dir_up ? a_ptr + pme_pkg::ADDR_W'(1) : a_ptr - pme_pkg::ADDR_W'(1);
  assign last_shift = (step_ptr == b_ptr);
  // Another pair remains when lo + 1 < hi - 1
  assign more_pairs = is_inv && (int'(b_ptr - a_ptr) > 2);

  pme_ram #(
    .DEPTH_P (pme_pkg::DEPTH),
    .ADDR_W  (pme_pkg::ADDR_W),
    .DATA_W  (pme_pkg::ELEM_WIDTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pme_pkg::ST_IDLE: begin
        if (acc) begin
          if (req.func == pme_pkg::FN_READ) begin
            state_next = pme_pkg::ST_RESP;
          end else if (req_move) begin
            if (req.func == pme_pkg::FN_INSERT || req.func == pme_pkg::FN_REV_INSERT) begin
              state_next = pme_pkg::ST_SHIFT;
            end else begin
              state_next = pme_pkg::ST_PAIR_WA;
            end
          end
        end
      end
      pme_pkg::ST_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = pme_pkg::ST_IDLE;
        end
      end
      pme_pkg::ST_PAIR_RD: state_next = pme_pkg::ST_PAIR_WA;
      pme_pkg::ST_PAIR_WA: state_next = pme_pkg::ST_PAIR_WB;
      pme_pkg::ST_PAIR_WB: state_next = more_pairs ? pme_pkg::ST_PAIR_RD : pme_pkg::ST_IDLE;
      pme_pkg::ST_SHIFT:   state_next = last_shift ? pme_pkg::ST_TAIL : pme_pkg::ST_SHIFT;
      pme_pkg::ST_TAIL:    state_next = pme_pkg::ST_IDLE;
      default:             state_next = pme_pkg::ST_IDLE;
    endcase
  end

  // Store control and response load
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_ptr;
    ram_wdata = rdata_b;
    raddr_a   = a_ptr;
    raddr_b   = b_ptr;
    rsp_load  = 1'b0;
    unique case (state)
      pme_pkg::ST_IDLE: begin
        // Issue the first reads straight from the request
        if (req.func == pme_pkg::FN_READ) begin
          raddr_a = pa;
        end else if (req.func == pme_pkg::FN_REV_INSERT) begin
          raddr_a = req_hi;
        end else begin
          raddr_a = req_lo;
        end
        if (req.func == pme_pkg::FN_INSERT) begin
          raddr_b = req_lo + pme_pkg::ADDR_W'(1);
        end else if (req.func == pme_pkg::FN_REV_INSERT) begin
          raddr_b = req_hi - pme_pkg::ADDR_W'(1);
        end else begin
          raddr_b = req_hi;
        end
        ram_we    = acc && (req.func == pme_pkg::FN_WRITE) && in_a;
        ram_waddr = pa;
        ram_wdata = pme_pkg::ELEM_WIDTH'(req.value);
      end
      pme_pkg::ST_RESP: begin
        rsp_load = !rsp_valid || !rsp_stall;
      end
      pme_pkg::ST_PAIR_RD: begin
        ram_we = 1'b0;
      end
      pme_pkg::ST_PAIR_WA: begin
        ram_we    = 1'b1;
        ram_waddr = a_ptr;
        ram_wdata = rdata_b;
      end
      pme_pkg::ST_PAIR_WB: begin
        ram_we    = 1'b1;
        ram_waddr = b_ptr;
        ram_wdata = held;
      end
      pme_pkg::ST_SHIFT: begin
        // Fill the destination with its neighbour, fetch the one after
        ram_we    = 1'b1;
        ram_waddr = a_ptr;
        ram_wdata = rdata_b;
        raddr_b   = dir_up ? a_ptr + pme_pkg::ADDR_W'(2) : a_ptr - pme_pkg::ADDR_W'(2);
      end
      pme_pkg::ST_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = b_ptr;
        ram_wdata = held;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pme_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      pme_pkg::ST_IDLE: begin
        if (acc) begin
          // Latch the move geometry; reverse insertion runs downwards
          if (req.func == pme_pkg::FN_READ) begin
            a_ptr <= pa;
          end else if (req.func == pme_pkg::FN_REV_INSERT) begin
            a_ptr <= req_hi;
          end else begin
            a_ptr <= req_lo;
          end
          b_ptr  <= (req.func == pme_pkg::FN_REV_INSERT) ? req_lo : req_hi;
          dir_up <= (req.func != pme_pkg::FN_REV_INSERT);
          is_inv <= (req.func == pme_pkg::FN_INVERT);
          rd_pos <= req.pos_a;
          rd_oob <= !in_a;
          first  <= 1'b1;
        end
      end
      pme_pkg::ST_RESP: begin
        if (rsp_load) begin
          rsp.read_value <= rd_oob ? '0 : pme_pkg::VALUE_W'(rdata_a);
          rsp.read_pos   <= rd_pos;
        end
      end
      pme_pkg::ST_PAIR_RD: begin
        first <= 1'b0;
      end
      pme_pkg::ST_PAIR_WA: begin
        held <= rdata_a;
      end
      pme_pkg::ST_PAIR_WB: begin
        a_ptr <= a_ptr + pme_pkg::ADDR_W'(1);
        b_ptr <= b_ptr - pme_pkg::ADDR_W'(1);
      end
      pme_pkg::ST_SHIFT: begin
        // Hold the element leaving the start of the segment
        if (first) begin
          held <= rdata_a;
        end
        first <= 1'b0;
        a_ptr <= step_ptr;
      end
      pme_pkg::ST_TAIL: begin
        first <= 1'b0;
      end
      default: first <= 1'b0;
    endcase
  end

endmodule

// File: src/pme_checker.sv
// Port-level checks for permutation_move_engine_core, bound to the top level.
// Depends on pme_pkg.
`timescale 1ns / 1ps

module pme_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input pme_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input pme_pkg::rsp_t rsp
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed or dropped");

  // A read keeps the block busy for the following cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.func == pme_pkg::FN_READ |=> req_stall)
    else $error("read did not occupy the block");

  // A write completes in its own cycle
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.func == pme_pkg::FN_WRITE |=> !req_stall)
    else $error("write held the request channel");

  // A new response only follows a busy cycle
  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response appeared without a read in progress");

endmodule

bind permutation_move_engine_core pme_checker u_pme_checker (.*);
